FILE: design/lmdd_pkg.sv
// ----------------------------------------------------------------------------
// Lock manager package
// Shared types, operation codes and default sizes for the lock manager with
// wait-for-graph deadlock detection.
// ----------------------------------------------------------------------------
`default_nettype none

package lmdd_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int DEF_THREADS = 8;
    localparam int DEF_LOCKS   = 8;

    // Operation codes.
    localparam logic [1:0] OP_LOCK    = 2'd0;
    localparam logic [1:0] OP_TRY     = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_DETECT  = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] thread_id;
        logic [2:0] lock_id;
    } t_in;

    typedef struct packed {
        logic       granted;
        logic       queued;
        logic       woken_valid;
        logic [2:0] woken_thread;
        logic       deadlock;
        logic [2:0] cycle_thread;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // capture the request
        logic walk_init;  // start a detection walk from thread zero
        logic exec;       // carry out a lock, try or release request
        logic step;       // take one step of the detection walk
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_detect;  // the offered request is a detection
        logic out_free;   // the result register can be loaded this cycle
        logic walk_done;  // the current walk step finishes the detection
    } t_sts;

endpackage

`default_nettype wire

FILE: design/lmdd_ctrl.sv
// ----------------------------------------------------------------------------
// Lock manager controller
// Sequences request capture, lock execution and the detection walk.
// ----------------------------------------------------------------------------
`default_nettype none

module lmdd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lmdd_pkg::t_sts i_sts,
    output lmdd_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    if (i_sts.is_detect) begin
                        o_cmd.walk_init = 1'b1;
                        n_state         = S_WALK;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                // Wait until the result register can take the outcome.
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_WALK: begin
                if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.walk_done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/lmdd_dpath.sv
// ----------------------------------------------------------------------------
// Lock manager datapath
// Owner and waiter tables, the detection walk registers and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module lmdd_dpath #(
    parameter int THREADS = lmdd_pkg::DEF_THREADS,
    parameter int LOCKS   = lmdd_pkg::DEF_LOCKS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lmdd_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output lmdd_pkg::t_out     o_out_data,
    input  wire lmdd_pkg::t_cmd i_cmd,
    output lmdd_pkg::t_sts     o_sts
);

    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int LW = (LOCKS > 1) ? $clog2(LOCKS) : 1;
    localparam logic [TW-1:0] T_LAST = TW'(THREADS - 1);

    // Tables. The valid bits are reset; the payload beside them is only
    // read while its valid bit is set.
    logic [LOCKS-1:0]   r_owner_valid;
    logic [TW-1:0]      r_owner_thread [LOCKS];
    logic [THREADS-1:0] r_wait_valid;
    logic [LW-1:0]      r_wait_lock [THREADS];

    // Captured request.
    logic [1:0]         r_op;
    logic [2:0]         r_thread;
    logic [2:0]         r_lock;

    // Detection walk.
    logic [TW-1:0]      r_start;
    logic [TW-1:0]      r_cur;
    logic [TW-1:0]      r_step;

    // Result register.
    logic               r_out_valid;
    lmdd_pkg::t_out     r_out;

    // Request decode.
    logic               l_ok;
    logic               t_ok;
    logic [LW-1:0]      li;
    logic [TW-1:0]      ti;
    logic               owned;
    logic               found;
    logic [TW-1:0]      widx;
    logic               do_release;
    logic               do_grant;
    logic               do_queue;

    // Walk decode.
    logic [LW-1:0]      w_lock;
    logic               edge_ok;
    logic [TW-1:0]      nxt;
    logic               hit;
    logic               fail;
    logic               last_start;

    logic               out_free;
    logic               load_out;
    lmdd_pkg::t_out     n_out;

    assign l_ok  = 32'(r_lock) < LOCKS;
    assign t_ok  = 32'(r_thread) < THREADS;
    assign li    = LW'(r_lock);
    assign ti    = TW'(r_thread);
    assign owned = l_ok && r_owner_valid[li];

    // Lowest-numbered thread waiting on the addressed lock.
    always_comb begin
        found = 1'b0;
        widx  = '0;
        for (int k = 0; k < THREADS; k++) begin
            if (!found && r_wait_valid[k] && (r_wait_lock[k] == li)) begin
                found = 1'b1;
                widx  = TW'(k);
            end
        end
    end

    assign do_release = i_cmd.exec && (r_op == lmdd_pkg::OP_RELEASE) && owned;
    assign do_grant   = i_cmd.exec && (r_op != lmdd_pkg::OP_RELEASE) && l_ok && t_ok
                        && !owned;
    assign do_queue   = i_cmd.exec && (r_op == lmdd_pkg::OP_LOCK) && t_ok && owned;

    // One edge of the wait-for graph from the current thread.
    assign w_lock     = r_wait_lock[r_cur];
    assign edge_ok    = r_wait_valid[r_cur] && r_owner_valid[w_lock];
    assign nxt        = r_owner_thread[w_lock];
    assign hit        = edge_ok && (nxt == r_start);
    assign fail       = !edge_ok || (!hit && (r_step == T_LAST));
    assign last_start = r_start == T_LAST;

    assign out_free = !r_out_valid || i_out_ready;
    assign load_out = i_cmd.exec || (i_cmd.step && (hit || (fail && last_start)));

    always_comb begin
        n_out              = '0;
        n_out.granted      = do_grant;
        n_out.queued       = do_queue;
        n_out.woken_valid  = do_release && found;
        n_out.woken_thread = (do_release && found) ? 3'(widx) : 3'd0;
        n_out.deadlock     = i_cmd.step && hit;
        n_out.cycle_thread = (i_cmd.step && hit) ? 3'(r_start) : 3'd0;
    end

    assign o_sts.is_detect = i_in_data.op == lmdd_pkg::OP_DETECT;
    assign o_sts.out_free  = out_free;
    assign o_sts.walk_done = hit || (fail && last_start);

    // Valid bits and result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner_valid <= '0;
            r_wait_valid  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (do_grant) begin
                r_owner_valid[li] <= 1'b1;
                r_wait_valid[ti]  <= 1'b0;
            end
            if (do_queue) begin
                r_wait_valid[ti] <= 1'b1;
            end
            if (do_release) begin
                if (found) begin
                    r_wait_valid[widx] <= 1'b0;
                end else begin
                    r_owner_valid[li] <= 1'b0;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op     <= i_in_data.op;
            r_thread <= i_in_data.thread_id;
            r_lock   <= i_in_data.lock_id;
        end
        if (do_grant) begin
            r_owner_thread[li] <= ti;
        end
        if (do_queue) begin
            r_wait_lock[ti] <= li;
        end
        if (do_release && found) begin
            r_owner_thread[li] <= widx;
        end
        if (load_out) begin
            r_out <= n_out;
        end
        if (i_cmd.walk_init) begin
            r_start <= '0;
            r_cur   <= '0;
            r_step  <= '0;
        end else if (i_cmd.step && !hit) begin
            if (fail) begin
                r_start <= r_start + 1'b1;
                r_cur   <= r_start + 1'b1;
                r_step  <= '0;
            end else begin
                r_cur  <= nxt;
                r_step <= r_step + 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: design/lock_manager_deadlock_detect.sv
// ----------------------------------------------------------------------------
// Lock manager with deadlock detection
// Binary locks with an owner per lock, a waited-on lock per thread, and a
// walk of the wait-for graph that reports a thread on a cycle.
// ----------------------------------------------------------------------------
// Lock, try and release requests are taken in idle, then executed once the
// result register is free: the tables update and the result is loaded.
// A detection then walks the graph while the result register is free, at
// most THREADS*THREADS steps (64 at the defaults).
// One request is in work at a time; the next may be taken while a result
// still waits in the result register. Reset (synchronous, active low) frees
// every lock, clears every waiter and empties the result register.
`default_nettype none

module lock_manager_deadlock_detect #(
    parameter int THREADS = lmdd_pkg::DEF_THREADS,
    parameter int LOCKS   = lmdd_pkg::DEF_LOCKS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lmdd_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output lmdd_pkg::t_out     o_out_data
);

    // The controller only steers; every table, the captured request and the
    // walk pointers live in the datapath. They talk through a command struct
    // one way and a status struct the other.
    lmdd_pkg::t_cmd cmd;
    lmdd_pkg::t_sts sts;

    // The controller is idle when it can take a transfer. A lock-style
    // request moves to the execute state, a detection to the walk.
    // Both hold back while the result register is full and not being read,
    // so a finished result is never overwritten.
    lmdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The walk visits start threads in ascending order and follows waiter
    // to owner edges up to THREADS steps from each; the first start that
    // returns to itself is reported, which is the lowest thread on a cycle.
    lmdd_dpath #(
        .THREADS (THREADS),
        .LOCKS   (LOCKS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire
